// ===== src/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Control bundle between the sequencer and the datapath, the initial hash
// values, the round constant table and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   // Control bundle driven by the sequencer to the schedule and round units.
   typedef struct packed {
      logic       load;       // shift one byte into the block window
      logic [7:0] data_val;   // byte to shift in
      logic       start;      // copy the chaining words into the working words
      logic       round;      // perform one compression round
      logic [5:0] round_idx;  // index of that round
      logic       add;        // fold the working words into the chaining words
      logic       init;       // return the chaining words to the initial values
   } ctl_type;

   localparam logic [31:0] IV0 = 32'h6a09e667;
   localparam logic [31:0] IV1 = 32'hbb67ae85;
   localparam logic [31:0] IV2 = 32'h3c6ef372;
   localparam logic [31:0] IV3 = 32'ha54ff53a;
   localparam logic [31:0] IV4 = 32'h510e527f;
   localparam logic [31:0] IV5 = 32'h9b05688c;
   localparam logic [31:0] IV6 = 32'h1f83d9ab;
   localparam logic [31:0] IV7 = 32'h5be0cd19;

   // Right rotation of a 32-bit word by a constant amount.
   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   // Round constant table.
   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

// ===== src/sha256_sched.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block window and message schedule
// A 512-bit shift line that collects message bytes and, during compression,
// slides one schedule word per round while appending the next expanded word.
// ----------------------------------------------------------------------------
module sha256_sched
   import sha256_pkg::*;
(
   input  logic        clock,
   input  ctl_type     ctl,
   output logic [31:0] w_now
);

   logic [511:0] blk_ff;
   logic [511:0] blk_in;
   logic [31:0]  w_new;

   // The oldest word of the window is the schedule word of the current round.
   assign w_now = blk_ff[511:480];

   // Next schedule word from the taps t, t+1, t+9 and t+14 of the window.
   assign w_new = ssig1(blk_ff[63:32]) + blk_ff[223:192] + ssig0(blk_ff[479:448])
                + blk_ff[511:480];

   // Bytes enter at the low end; rounds drop the oldest word and append a new one.
   always_comb begin
      blk_in = blk_ff;
      if (ctl.load) begin
         blk_in = {blk_ff[503:0], ctl.data_val};
      end else if (ctl.round) begin
         blk_in = {blk_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

endmodule

// ===== src/sha256_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Eight working words updated by one shared round per cycle, and the eight
// chaining words that collect the result of each block.
// ----------------------------------------------------------------------------
module sha256_round
   import sha256_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctl_type      ctl,
   input  logic [31:0]  w_now,
   output logic [255:0] digest   // H1, H0, H3, H2, H5, H4, H7, H6 from bit 0 up
);

   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   // Round function on the current working words.
   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + bsig1(v_ff[4]) + ch + round_k(ctl.round_idx) + w_now;
   assign t2  = bsig0(v_ff[0]) + maj;

   // Working words: loaded at block start, rotated once per round.
   always_comb begin
      v_in = v_ff;
      if (ctl.start) begin
         v_in = h_ff;
      end else if (ctl.round) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   // Chaining words: initial values on a new message, sum at the end of a block.
   always_comb begin
      h_in = h_ff;
      if (ctl.init) begin
         h_in[0] = IV0;
         h_in[1] = IV1;
         h_in[2] = IV2;
         h_in[3] = IV3;
         h_in[4] = IV4;
         h_in[5] = IV5;
         h_in[6] = IV6;
         h_in[7] = IV7;
      end else if (ctl.add) begin
         for (int i = 0; i < 8; i++) begin
            h_in[i] = h_ff[i] + v_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0] <= IV0;
         h_ff[1] <= IV1;
         h_ff[2] <= IV2;
         h_ff[3] <= IV3;
         h_ff[4] <= IV4;
         h_ff[5] <= IV5;
         h_ff[6] <= IV6;
         h_ff[7] <= IV7;
      end else begin
         h_ff <= h_in;
      end
   end

   // Digest words laid out so that the first digest word sits in the low bits.
   assign digest = {h_ff[6], h_ff[7], h_ff[4], h_ff[5], h_ff[2], h_ff[3], h_ff[0], h_ff[1]};

endmodule

// ===== src/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a message that arrives one byte per transaction and returns the
// 256-bit digest as one result transaction at the end of each message.
//
//  channel | dir | tdata                       | tuser      | tlast
//  req     | in  | [7:0] data_byte             | byte_valid | end_of_message
//  rsp     | out | [63:0] digest_word0 .. [255:192] digest_word3 | - | -
//
// The 64th byte of a block starts compression (64 rounds of the shared round unit
// and one chaining add) with req_tready low. End of message feeds the pad bytes
// one per cycle up to the block end (at most 72 over two blocks), with one or two
// compressions, then loads the result register. That last step waits while an
// earlier digest is still unaccepted on rsp.
// Reset is synchronous and restores the initial hash values and empty counts.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
   import sha256_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] byte_valid
   input  logic         req_tlast,   // end_of_message
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [255:0] rsp_tdata    // [63:0] digest_word0, [127:64] digest_word1,
                                     // [191:128] digest_word2, [255:192] digest_word3
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PAD  = 2'd1;
   localparam logic [1:0] S_COMP = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [6:0] LAST_ROUND = 7'd63;
   localparam logic [5:0] LEN_START  = 6'd56;
   localparam logic [5:0] LAST_POS   = 6'd63;

   logic [1:0]   state_ff, state_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  cnt_ff, cnt_in;
   logic         pad_mode_ff, pad_mode_in;
   logic         pad_first_ff, pad_first_in;
   logic         pad_wrap_ff, pad_wrap_in;
   logic         final_blk_ff, final_blk_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [255:0] rsp_data_ff;

   logic         accept;
   logic         load_out;
   logic [63:0]  len_bits;
   logic [63:0]  len_shift;
   logic [31:0]  w_now;
   logic [255:0] digest;
   ctl_type      ctl;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Message length in bits, and the byte of it that belongs at the current place.
   assign len_bits  = {cnt_ff, 3'b000};
   assign len_shift = len_bits >> {~fill_ff[2:0], 3'b000};

   // Result register is free when empty or being emptied in this cycle.
   assign load_out = (state_ff == S_FIN) & (~rsp_valid_ff | rsp_tready);

   // Sequencer: byte intake, padding, round count and result hand-off.
   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      pad_mode_in  = pad_mode_ff;
      pad_first_in = pad_first_ff;
      pad_wrap_in  = pad_wrap_ff;
      final_blk_in = final_blk_ff;
      ctl          = '0;
      ctl.round_idx = rnd_ff[5:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tlast) begin
                  pad_mode_in  = 1'b1;
                  pad_first_in = 1'b1;
                  state_in     = S_PAD;
               end
               if (req_tuser) begin
                  ctl.load     = 1'b1;
                  ctl.data_val = req_tdata;
                  fill_in      = fill_ff + 6'd1;
                  cnt_in       = cnt_ff + 61'd1;
                  if (fill_ff == LAST_POS) begin
                     ctl.start = 1'b1;
                     rnd_in    = '0;
                     state_in  = S_COMP;
                  end
               end
            end
         end
         S_PAD: begin
            ctl.load = 1'b1;
            fill_in  = fill_ff + 6'd1;
            if (pad_first_ff) begin
               // The marker byte; landing in the length field it forces an extra block.
               ctl.data_val = PAD_MARK;
               pad_first_in = 1'b0;
               if (fill_ff >= LEN_START) begin
                  pad_wrap_in = 1'b1;
               end
            end else if ((fill_ff >= LEN_START) && !pad_wrap_ff) begin
               ctl.data_val = len_shift[7:0];
               if (fill_ff == LAST_POS) begin
                  final_blk_in = 1'b1;
               end
            end else begin
               ctl.data_val = '0;
            end
            if (fill_ff == LAST_POS) begin
               ctl.start   = 1'b1;
               pad_wrap_in = 1'b0;
               rnd_in      = '0;
               state_in    = S_COMP;
            end
         end
         S_COMP: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff <= LAST_ROUND) begin
               ctl.round = 1'b1;
            end else begin
               ctl.add = 1'b1;
               rnd_in  = '0;
               if (final_blk_ff) begin
                  state_in = S_FIN;
               end else if (pad_mode_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FIN: begin
            if (load_out) begin
               ctl.init     = 1'b1;
               fill_in      = '0;
               cnt_in       = '0;
               pad_mode_in  = 1'b0;
               pad_first_in = 1'b0;
               pad_wrap_in  = 1'b0;
               final_blk_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result valid: set on a new digest, cleared once the transaction completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rnd_ff       <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         pad_mode_ff  <= 1'b0;
         pad_first_ff <= 1'b0;
         pad_wrap_ff  <= 1'b0;
         final_blk_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         pad_mode_ff  <= pad_mode_in;
         pad_first_ff <= pad_first_in;
         pad_wrap_ff  <= pad_wrap_in;
         final_blk_ff <= final_blk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= digest;
      end
   end

   sha256_sched u_sched (
      .clock (clock),
      .ctl   (ctl),
      .w_now (w_now)
   );

   sha256_round u_round (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .w_now  (w_now),
      .digest (digest)
   );

`ifndef SYNTH
   // The round counter only moves while a block is being compressed.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_COMP) |-> (rnd_ff == '0))
      else $error("round counter active outside compression");

   // Padding flags only exist while a message is being finished.
   assert property (@(posedge clock) disable iff (reset)
      (pad_wrap_ff || final_blk_ff || pad_first_ff) |-> pad_mode_ff)
      else $error("padding flag set without padding in progress");

   // A result only appears after the finishing step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("result raised outside the finishing step");

   // Handing off a digest leaves an empty message behind.
   assert property (@(posedge clock) disable iff (reset)
      load_out |=> ((cnt_ff == '0) && (fill_ff == '0) && (state_ff == S_IDLE)))
      else $error("message state not cleared after digest hand-off");
`endif

endmodule

// ===== tb/sha256_digest_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches the request and response channels of the byte stream hasher. Every
// accepted request transaction is run through a local SHA-256 model, and each
// end of message queues the digest that the block should return. Response
// transactions are compared word by word against the oldest queued digest.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] byte_valid
   input  logic         req_tlast,   // end_of_message
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [255:0] rsp_tdata,   // [63:0] digest_word0 .. [255:192] digest_word3
   output int           mismatch_count,
   output int           digests_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // Layout matches rsp_tdata, so a response can be assigned straight in.
   typedef struct packed {
      logic [63:0] digest_word3;
      logic [63:0] digest_word2;
      logic [63:0] digest_word1;
      logic [63:0] digest_word0;
   } digest_type;

   localparam logic [0:7][31:0] HASH_INIT = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // Model state: chaining words, the partly filled block and the byte count.
   logic [31:0] chain_h [8];
   logic [7:0]  block_buf [64];
   int          block_fill;
   logic [60:0] msg_bytes;
   digest_type  expected_digests [$];

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      logic [63:0] twice;
      twice = {x, x} >> n;
      return twice[31:0];
   endfunction

   // One SHA-256 compression of block_buf into the chaining words.
   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      int          i;
      for (i = 0; i < 16; i++) begin
         w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      end
      for (i = 16; i < 64; i++) begin
         w[i] = w[i-16] + w[i-7]
              + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
              + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
      e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
      for (i = 0; i < 64; i++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + ROUND_K[i] + w[i];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
      chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
   endtask

   // Append one byte to the block; a full block is compressed at once.
   task automatic absorb_byte(input logic [7:0] value);
      block_buf[block_fill] = value;
      block_fill++;
      if (block_fill == 64) begin
         compress_block();
         block_fill = 0;
      end
   endtask

   task automatic restart_message();
      int i;
      for (i = 0; i < 8; i++) chain_h[i] = HASH_INIT[i];
      block_fill = 0;
      msg_bytes  = '0;
   endtask

   // Runs one request through the model and queues a digest at end of message.
   task automatic hash_request(input logic [7:0] value, input logic is_byte,
                               input logic is_end);
      logic [63:0] bit_len;
      digest_type  digest;
      int          i;
      if (is_byte) begin
         absorb_byte(value);
         msg_bytes++;
      end
      if (is_end) begin
         bit_len = {msg_bytes, 3'b000};
         // Pad marker, zero fill up to the length field, then the bit length.
         absorb_byte(8'h80);
         while (block_fill != 56) absorb_byte(8'h00);
         for (i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
         digest.digest_word0 = {chain_h[0], chain_h[1]};
         digest.digest_word1 = {chain_h[2], chain_h[3]};
         digest.digest_word2 = {chain_h[4], chain_h[5]};
         digest.digest_word3 = {chain_h[6], chain_h[7]};
         expected_digests = {expected_digests, digest};
         restart_message();
      end
   endtask

   task automatic compare_word(input string name, input logic [63:0] exp_word,
                               input logic [63:0] act_word);
      if (act_word !== exp_word) begin
         $error("%s mismatch: expected %h, actual %h", name, exp_word, act_word);
         mismatch_count++;
      end
   endtask

   initial begin
      mismatch_count = 0;
      digests_owed   = 0;
   end

   // Requests are modelled before responses are checked in the same cycle.
   always @(posedge clock) begin
      digest_type want;
      digest_type got;
      if (reset) begin
         restart_message();
         expected_digests.delete();
      end else begin
         if (req_tvalid && req_tready) hash_request(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_digests.size() == 0) begin
               $error("unexpected response transaction: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_digests.pop_front();
               compare_word("digest_word0", want.digest_word0, got.digest_word0);
               compare_word("digest_word1", want.digest_word1, got.digest_word1);
               compare_word("digest_word2", want.digest_word2, got.digest_word2);
               compare_word("digest_word3", want.digest_word3, got.digest_word3);
            end
         end
      end
      digests_owed = expected_digests.size();
   end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Sends a few directed messages (empty, short, ignored bytes, end of message
// with and without a byte) and then random messages whose lengths cluster
// round the padding and block boundaries, with random stalls on both
// channels. The checker predicts every digest; the verdict is given here.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1850;
   localparam int CALM_FROM    = 1550;
   localparam int TAIL_CYCLES  = 250;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] data_byte
   logic         req_tuser;   // [0] byte_valid
   logic         req_tlast;   // end_of_message
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [255:0] rsp_tdata;   // [63:0] digest_word0 .. [255:192] digest_word3

   int mismatch_count;
   int digests_owed;
   int items_sent;
   bit sender_stalls;
   bit sink_stalls;

   sha256_byte_stream_hasher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sha256_digest_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .digests_owed   (digests_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response sink: random bursts of back-pressure while stalls are enabled.
   initial begin : rsp_sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Drives one request transaction, starting and ending on a falling edge.
   task automatic send_item(input logic [7:0] value, input logic is_byte,
                            input logic is_end);
      int gap;
      if (sender_stalls && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= is_byte;
      req_tlast  <= is_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Holds the request channel idle until every queued digest has come back.
   task automatic wait_for_digests();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (digests_owed != 0);
   endtask

   // A message of the given length, sometimes with ignored transactions mixed
   // in, and ended either on its last byte or by a separate end transaction.
   task automatic send_message(input int len);
      bit separate_end;
      int i;
      separate_end = (len == 0) || ($urandom_range(0, 3) == 0);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, (i == len - 1) && !separate_end);
         items_sent++;
      end
      if (separate_end) begin
         send_item(8'($urandom), 1'b0, 1'b1);
         items_sent++;
      end
   endtask

   // Lengths near the 55/56 padding split and the 64-byte block edge are
   // favoured; a few long messages span two to four blocks.
   function automatic int pick_length();
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            case ($urandom_range(0, 11))
               0:  return 55;
               1:  return 56;
               2:  return 57;
               3:  return 63;
               4:  return 64;
               5:  return 65;
               6:  return 119;
               7:  return 120;
               8:  return 127;
               9:  return 128;
               10: return 0;
               default: return 1;
            endcase
         end
         9:       return $urandom_range(66, 200);
         default: return $urandom_range(0, 32);
      endcase
   endfunction

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tuser     = 1'b0;
      req_tlast     = 1'b0;
      sender_stalls = 1'b1;
      sink_stalls   = 1'b1;
      items_sent    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty message; the data byte is ignored since byte_valid is low.
      send_item(8'hff, 1'b0, 1'b1);
      // "abc", ended on its last byte.
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      // Idle transaction inside a message, extreme bytes, separate end.
      send_item(8'ha5, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h5a, 1'b0, 1'b1);
      // One-byte messages at both extremes.
      send_item(8'hff, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      // Ignored byte between two valid ones.
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h33, 1'b0, 1'b0);
      send_item(8'h7f, 1'b1, 1'b1);

      wait_for_digests();

      // Random messages; stalls switch on and off, and stop near the end.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= CALM_FROM) begin
            sender_stalls <= 1'b0;
            sink_stalls   <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            sender_stalls <= 1'($urandom_range(0, 1));
            sink_stalls   <= 1'($urandom_range(0, 1));
         end
         if ($urandom_range(0, 11) == 0) wait_for_digests();
         send_message(pick_length());
      end

      wait_for_digests();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && digests_owed == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Run limit, well above the slowest correct run.
   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
src/sha256_pkg.sv
src/sha256_sched.sv
src/sha256_round.sv
src/sha256_byte_stream_hasher.sv
tb/sha256_digest_checker.sv
tb/tb.sv
